// ===== rtl/core/rlcg_pkg.sv =====
// Package for the ranged LCG random generator: constants, codes and shared types.
// Depends on nothing; the front end, queue, back end and top level refer to it by scoped names.
package rlcg_pkg;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [31:0] SMALL_DELTA_LIMIT = 32'h0001_0000;
    localparam logic [63:0] SEED_RESET = 64'd1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_DRAW32 = 2'd0,
        ACT_DRAW64 = 2'd1,
        ACT_RANGED = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Classified command handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_ZERO,
        CMD_CONST,
        CMD_DRAW32,
        CMD_DRAW64,
        CMD_MOD32,
        CMD_MOD64
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] base;
        logic [31:0] delta;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ADD,
        ST_NEXT,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } back_state_t;

endpackage

// ===== rtl/core/rlcg_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
// Depends on nothing.
interface rlcg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] lower;
    logic [31:0] upper;
    modport source (output valid, action, lower, upper, input ready);
    modport sink (input valid, action, lower, upper, output ready);
endinterface

interface rlcg_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    modport source (output valid, value, input ready);
    modport sink (input valid, value, output ready);
endinterface

// ===== rtl/core/rlcg_front.sv =====
// Front end: takes transfers, narrows swapped bounds, classifies each item.
// Depends on rlcg_pkg and rlcg_if.
module rlcg_front (
    rlcg_in_if.sink         in_ch,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output rlcg_pkg::cmd_t  cmd
);
    logic [31:0] lo_w;
    logic [31:0] hi_w;
    logic [31:0] delta_w;

    assign cmd_valid = in_ch.valid;
    assign in_ch.ready = cmd_ready;

    always_comb
    begin
        if (in_ch.lower > in_ch.upper)
        begin
            lo_w = in_ch.upper + 32'd1;
            hi_w = in_ch.lower - 32'd1;
        end
        else
        begin
            lo_w = in_ch.lower;
            hi_w = in_ch.upper;
        end
        delta_w = hi_w - lo_w;
        cmd.base = lo_w;
        cmd.delta = delta_w;
        case (rlcg_pkg::action_t'(in_ch.action))
            rlcg_pkg::ACT_DRAW32: cmd.kind = rlcg_pkg::CMD_DRAW32;
            rlcg_pkg::ACT_DRAW64: cmd.kind = rlcg_pkg::CMD_DRAW64;
            rlcg_pkg::ACT_RANGED:
            begin
                if (delta_w == 32'd0)
                    cmd.kind = rlcg_pkg::CMD_CONST;
                else if (delta_w < rlcg_pkg::SMALL_DELTA_LIMIT)
                    cmd.kind = rlcg_pkg::CMD_MOD32;
                else
                    cmd.kind = rlcg_pkg::CMD_MOD64;
            end
            default: cmd.kind = rlcg_pkg::CMD_ZERO;
        endcase
    end
endmodule

// ===== rtl/core/rlcg_queue.sv =====
// Short command queue between the front and back ends.
// Depends on rlcg_pkg.
module rlcg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rlcg_pkg::cmd_t  wr_cmd,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rlcg_pkg::cmd_t  rd_cmd
);
    rlcg_pkg::cmd_t slot_reg [rlcg_pkg::QUEUE_DEPTH];
    logic wptr_reg;
    logic rptr_reg;
    logic [1:0] count_reg;
    logic do_wr;
    logic do_rd;

    assign wr_ready = (count_reg != 2'(rlcg_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd = slot_reg[rptr_reg];
    assign do_wr = wr_valid & wr_ready;
    assign do_rd = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= ~wptr_reg;
            if (do_rd)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(rlcg_pkg::QUEUE_DEPTH)) else $error("queue overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count slip");
    a_empty_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !do_rd) else $error("read from empty queue");
endmodule

// ===== rtl/core/rlcg_back.sv =====
// Back end: LCG steps on a shared 32x32 multiplier, serial 64-bit remainder, result register.
// Depends on rlcg_pkg and rlcg_if.
module rlcg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seed_we,
    input  logic [63:0]     seed_data,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  rlcg_pkg::cmd_t  cmd,
    rlcg_out_if.source      out_ch
);
    rlcg_pkg::back_state_t state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] lcg_reg, lcg_next;
    logic [63:0] src_reg, src_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] draw_reg, draw_next;
    logic        second_reg, second_next;
    rlcg_pkg::cmd_t cmd_reg, cmd_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg, out_value_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [64:0] rem_shift;
    logic        take;

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign take = cmd_valid & cmd_ready;
    assign cmd_ready = (state_reg == rlcg_pkg::ST_IDLE) & ~out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = out_value_reg;
    assign rem_shift = {rem_reg, quo_reg[63]};

    always_comb
    begin
        case (state_reg)
            rlcg_pkg::ST_MUL0: begin mul_a = src_reg[31:0];  mul_b = rlcg_pkg::LCG_MUL[31:0];  end
            rlcg_pkg::ST_MUL1: begin mul_a = src_reg[63:32]; mul_b = rlcg_pkg::LCG_MUL[31:0];  end
            rlcg_pkg::ST_MUL2: begin mul_a = src_reg[31:0];  mul_b = rlcg_pkg::LCG_MUL[63:32]; end
            default:           begin mul_a = 32'd0;          mul_b = 32'd0;                    end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlcg_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (cmd.kind)
                        rlcg_pkg::CMD_ZERO, rlcg_pkg::CMD_CONST:
                            state_next = rlcg_pkg::ST_DONE;
                        default:
                            state_next = rlcg_pkg::ST_MUL0;
                    endcase
                end
            end
            rlcg_pkg::ST_MUL0: state_next = rlcg_pkg::ST_MUL1;
            rlcg_pkg::ST_MUL1: state_next = rlcg_pkg::ST_MUL2;
            rlcg_pkg::ST_MUL2: state_next = rlcg_pkg::ST_ADD;
            rlcg_pkg::ST_ADD:  state_next = rlcg_pkg::ST_NEXT;
            rlcg_pkg::ST_NEXT:
            begin
                if ((cmd_reg.kind == rlcg_pkg::CMD_DRAW64 || cmd_reg.kind == rlcg_pkg::CMD_MOD64)
                    && !second_reg)
                    state_next = rlcg_pkg::ST_MUL0;
                else if (cmd_reg.kind == rlcg_pkg::CMD_MOD32
                         || cmd_reg.kind == rlcg_pkg::CMD_MOD64)
                    state_next = rlcg_pkg::ST_DIV;
                else
                    state_next = rlcg_pkg::ST_DONE;
            end
            rlcg_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'd63)
                    state_next = rlcg_pkg::ST_SUM;
            end
            rlcg_pkg::ST_SUM:  state_next = rlcg_pkg::ST_DONE;
            rlcg_pkg::ST_DONE: state_next = rlcg_pkg::ST_IDLE;
            default:           state_next = rlcg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        lcg_next = lcg_reg;
        src_next = src_reg;
        acc_next = acc_reg;
        draw_next = draw_reg;
        second_next = second_reg;
        cmd_next = cmd_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            rlcg_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd_next = cmd;
                    second_next = 1'b0;
                    draw_next = 64'd0;
                    // Reload the seed before the draw when the state has reached zero.
                    src_next = (lcg_reg == 64'd0) ? (seed_reg | 64'd1) : lcg_reg;
                end
            end
            rlcg_pkg::ST_MUL0: acc_next = mul_p;
            rlcg_pkg::ST_MUL1: acc_next = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
            rlcg_pkg::ST_MUL2: acc_next = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
            rlcg_pkg::ST_ADD:
            begin
                lcg_next = acc_reg + rlcg_pkg::LCG_ADD;
                draw_next = {draw_reg[31:0], lcg_next[63:32]};
            end
            rlcg_pkg::ST_NEXT:
            begin
                second_next = 1'b1;
                src_next = (lcg_reg == 64'd0) ? (seed_reg | 64'd1) : lcg_reg;
                rem_next = 64'd0;
                quo_next = draw_reg;
                cnt_next = 7'd0;
            end
            rlcg_pkg::ST_DIV:
            begin
                // One restoring step of the remainder per cycle, most significant bit first.
                quo_next = {quo_reg[62:0], 1'b0};
                if (rem_shift >= {33'd0, cmd_reg.delta})
                    rem_next = 64'(rem_shift - {33'd0, cmd_reg.delta});
                else
                    rem_next = rem_shift[63:0];
                cnt_next = cnt_reg + 7'd1;
            end
            rlcg_pkg::ST_SUM:
                draw_next = {32'd0, cmd_reg.base + rem_reg[31:0]};
            rlcg_pkg::ST_DONE:
            begin
                out_valid_next = 1'b1;
                case (cmd_reg.kind)
                    rlcg_pkg::CMD_ZERO:  out_value_next = 64'd0;
                    rlcg_pkg::CMD_CONST: out_value_next = {32'd0, cmd_reg.base};
                    default:             out_value_next = draw_reg;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlcg_pkg::ST_IDLE;
            seed_reg <= rlcg_pkg::SEED_RESET;
            lcg_reg <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_we)
                seed_reg <= seed_data;
            lcg_reg <= lcg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        acc_reg <= acc_next;
        draw_reg <= draw_next;
        second_reg <= second_next;
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        out_value_reg <= out_value_next;
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg != rlcg_pkg::ST_IDLE) else $error("command lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg) else $error("result dropped");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rlcg_pkg::ST_DONE |-> !out_valid_reg) else $error("result overwritten");
endmodule

// ===== rtl/core/ranged_lcg_random_generator.sv =====
// Top level of the ranged LCG random generator: front end, command queue and back end.
// Depends on rlcg_pkg, rlcg_if, rlcg_front, rlcg_queue and rlcg_back.
// One transfer in gives one transfer out. A plain draw takes one LCG step and a 64-bit
// draw two; a ranged draw takes one step when its span is below 65536 and two otherwise,
// followed by a 64-step serial remainder. The LCG step shares one 32x32 multiplier over
// the states MUL0, MUL1 and MUL2, and the remainder unit works through the drawn value
// one bit at a time, most significant bit first. A ranged draw whose span is zero and the
// unused action return without stepping the generator. The back end takes the next
// command only once the result has been transferred, so items are handled one at a time
// and a receiver that holds off delays the next item; the command queue accepts up to two
// further items meanwhile.
module ranged_lcg_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_init_we,
    input  logic [63:0] seed_init,
    rlcg_in_if.sink     in_ch,
    rlcg_out_if.source  out_ch
);
    logic           f_valid;
    logic           f_ready;
    rlcg_pkg::cmd_t f_cmd;
    logic           q_valid;
    logic           q_ready;
    rlcg_pkg::cmd_t q_cmd;

    rlcg_front u_front (
        .in_ch(in_ch),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    rlcg_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
    );

    rlcg_back u_back (
        .clk(clk), .rst_n(rst_n),
        .seed_we(seed_init_we), .seed_data(seed_init),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_ch(out_ch)
    );
endmodule
